// File: rtl/core/k_distinct_subarray_counter_defines.svh
// Assertion helpers used by the RTL that checks itself.
`ifndef K_DISTINCT_SUBARRAY_COUNTER_DEFINES_SVH
`define K_DISTINCT_SUBARRAY_COUNTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KDSC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("kdsc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KDSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("kdsc assertion failed");

`endif

// File: rtl/core/kdsc_pkg.sv
`default_nettype none
package kdsc_pkg;

	localparam int MAX_LEN     = 1024;
	localparam int VALUE_RANGE = 1024;

	localparam int VAL_W   = 10;
	localparam int HIST_AW = $clog2(MAX_LEN);
	localparam int LEN_W   = HIST_AW + 1;
	localparam int CNT_W   = 11;
	localparam int TGT_W   = 11;
	localparam int PFX_W   = 10;
	localparam int TOT_W   = 20;
	localparam int EPOCH_W = 4;

	localparam logic [EPOCH_W-1:0] EPOCH_MAX   = '1;
	localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_INC_RD,
		S_INC_WR,
		S_DROP_RD,
		S_DROP_WR,
		S_TRIM_HIST,
		S_TRIM_RD,
		S_TRIM_WR,
		S_FIN,
		S_DONE
	} kdsc_state_t;

	// one access to the frequency table
	typedef struct packed {
		logic [VAL_W-1:0] rd_addr;
		logic             wr_en;
		logic             clr;
		logic [VAL_W-1:0] wr_addr;
		logic [CNT_W-1:0] wr_count;
	} kdsc_cnt_req_t;

endpackage
`default_nettype wire

// File: rtl/core/k_distinct_subarray_counter.sv
`default_nettype none
// Counts subarrays holding exactly target_distinct different values.
// Input channel: value and start_new with in_valid / in_stall; one transaction
//   per array element, start_new marks the first element of an array.
// Output channel: good_subarrays, window_distinct, overflow with out_valid /
//   out_stall; exactly one result transaction per input transaction.
// Config: cfg_wr_en / cfg_wr_data write target_distinct; write only while idle.
// Flow: an accepted element is stored in the history and counted (INC_RD,
//   INC_WR); if the distinct count exceeds the target one head element is
//   dropped (DROP_RD, DROP_WR), then head elements held more than once are
//   trimmed (TRIM_RD, TRIM_WR). Each element is trimmed at most once. in_stall
//   stays high until the result is loaded. Elements past 1024 set overflow.
// Reset: clears all control state, then sweeps the 1024-entry table
//   (in_stall high). The table uses a 4-bit epoch tag, so a new array
//   costs nothing, except every 15th one, which re-runs the sweep.
// Stall: the result waits in an output register while out_stall is high; the
//   next input is accepted meanwhile but its result waits for the first.
`include "k_distinct_subarray_counter_defines.svh"
module k_distinct_subarray_counter
	import kdsc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [TGT_W-1:0] cfg_wr_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic [VAL_W-1:0] value,
	input  wire logic             start_new,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic      [TOT_W-1:0] good_subarrays,
	output logic      [TGT_W-1:0] window_distinct,
	output logic                  overflow
);

	kdsc_state_t state_q, state_d;

	// control / architectural state
	logic [TGT_W-1:0]   target_q;
	logic [LEN_W-1:0]   ws_q;        // window start
	logic [LEN_W-1:0]   len_q;       // elements stored for this array
	logic [TGT_W-1:0]   distinct_q;
	logic [PFX_W-1:0]   prefix_q;
	logic [TOT_W-1:0]   total_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [VAL_W-1:0]   clr_q;
	logic               pend_q;      // sweep was started by an item
	logic               out_valid_q;

	// payload
	logic [VAL_W-1:0]   v_q;
	logic [VAL_W-1:0]   head_q;
	logic               ovf_q;
	logic [TOT_W-1:0]   good_q;
	logic [TGT_W-1:0]   wdist_q;
	logic               oflag_q;

	// history memory
	logic [VAL_W-1:0]   hist [MAX_LEN];
	logic [VAL_W-1:0]   hist_rd_q;
	logic               hist_we;

	kdsc_cnt_req_t      req;
	logic [CNT_W-1:0]   rd_count;
	logic               cnt_zero;
	logic [TGT_W-1:0]   dist_inc;
	logic               trim_ok;
	logic               out_load;
	logic               in_acc;
	logic               len_full;
	logic [TOT_W:0]     sum;

	kdsc_count_table u_count_table (
		.clk      (clk),
		.req      (req),
		.epoch    (epoch_q),
		.rd_count (rd_count)
	);

	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist[len_q[HIST_AW-1:0]] <= v_q;
		end
		hist_rd_q <= hist[ws_q[HIST_AW-1:0]];
	end

	assign cnt_zero = (rd_count == '0);
	assign dist_inc = distinct_q + TGT_W'(cnt_zero);
	assign trim_ok  = (rd_count > CNT_W'(1));
	assign in_acc   = in_valid && !in_stall;
	assign len_full = (len_q == LEN_W'(MAX_LEN));
	assign sum      = {1'b0, total_q} + (TOT_W+1)'(prefix_q) + (TOT_W+1)'(1);

	always_comb begin
		state_d      = state_q;
		req          = '0;
		req.rd_addr  = v_q;
		req.wr_addr  = v_q;
		req.wr_count = rd_count + CNT_W'(1);
		hist_we      = 1'b0;
		out_load     = 1'b0;
		in_stall     = (state_q != S_IDLE);
		case (state_q)
			S_CLEAR: begin
				req.wr_en   = 1'b1;
				req.clr     = 1'b1;
				req.wr_addr = clr_q;
				if (clr_q == '1) begin
					state_d = pend_q ? S_INC_RD : S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					if (start_new && epoch_q == EPOCH_MAX) begin
						state_d = S_CLEAR;
					end else if (!start_new && len_full) begin
						state_d = S_DONE;
					end else begin
						state_d = S_INC_RD;
					end
				end
			end
			S_INC_RD: begin
				hist_we = 1'b1;
				state_d = S_INC_WR;
			end
			S_INC_WR: begin
				req.wr_en = 1'b1;
				// history at the window start was read this cycle
				state_d = (dist_inc > target_q) ? S_DROP_RD : S_TRIM_RD;
			end
			S_DROP_RD: begin
				req.rd_addr = hist_rd_q;
				state_d     = S_DROP_WR;
			end
			S_DROP_WR: begin
				req.wr_en    = 1'b1;
				req.wr_addr  = head_q;
				req.wr_count = cnt_zero ? '0 : rd_count - CNT_W'(1);
				state_d      = S_TRIM_HIST;
			end
			S_TRIM_HIST: begin
				state_d = (ws_q < len_q) ? S_TRIM_RD : S_FIN;
			end
			S_TRIM_RD: begin
				req.rd_addr = hist_rd_q;
				state_d     = S_TRIM_WR;
			end
			S_TRIM_WR: begin
				req.wr_addr  = head_q;
				req.wr_count = rd_count - CNT_W'(1);
				if (trim_ok) begin
					req.wr_en = 1'b1;
					state_d   = S_TRIM_HIST;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= TGT_W'(1);
			ws_q        <= '0;
			len_q       <= '0;
			distinct_q  <= '0;
			prefix_q    <= '0;
			total_q     <= '0;
			epoch_q     <= EPOCH_FIRST;
			clr_q       <= '0;
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				target_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + VAL_W'(1);
					if (clr_q == '1) begin
						epoch_q <= EPOCH_FIRST;
						pend_q  <= 1'b0;
					end
				end
				S_IDLE: begin
					if (in_acc && start_new) begin
						ws_q       <= '0;
						len_q      <= '0;
						distinct_q <= '0;
						prefix_q   <= '0;
						total_q    <= '0;
						if (epoch_q == EPOCH_MAX) begin
							pend_q <= 1'b1;
						end else begin
							epoch_q <= epoch_q + EPOCH_W'(1);
						end
					end
				end
				S_INC_WR: begin
					len_q      <= len_q + LEN_W'(1);
					distinct_q <= dist_inc;
				end
				S_DROP_WR: begin
					prefix_q   <= '0;
					distinct_q <= distinct_q - TGT_W'(1);
					ws_q       <= ws_q + LEN_W'(1);
				end
				S_TRIM_WR: begin
					if (trim_ok) begin
						prefix_q <= prefix_q + PFX_W'(1);
						ws_q     <= ws_q + LEN_W'(1);
					end
				end
				S_FIN: begin
					if (distinct_q == target_q) begin
						// saturate at the top of the 20-bit range
						total_q <= sum[TOT_W] ? '1 : sum[TOT_W-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			v_q   <= value;
			ovf_q <= !start_new && len_full;
		end
		if (state_q == S_DROP_RD || state_q == S_TRIM_RD) begin
			head_q <= hist_rd_q;
		end
		if (out_load) begin
			good_q  <= total_q;
			wdist_q <= distinct_q;
			oflag_q <= ovf_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign good_subarrays  = good_q;
	assign window_distinct = wdist_q;
	assign overflow        = oflag_q;

	`KDSC_ASSERT_IMPLY(a_ws_le_len, clk, arst_n, 1'b1, ws_q <= len_q)
	`KDSC_ASSERT_IMPLY(a_prefix_in_window, clk, arst_n, 1'b1, LEN_W'(prefix_q) <= ws_q)
	`KDSC_ASSERT_NEXT(a_accept_busy, clk, arst_n, in_acc, state_q != S_IDLE)
	`KDSC_ASSERT_IMPLY(a_epoch_live, clk, arst_n, state_q != S_CLEAR, epoch_q != '0)

endmodule
`default_nettype wire

// File: rtl/core/kdsc_count_table.sv
`default_nettype none
// Per-value frequency table. Each entry carries an epoch tag; an entry whose
// tag differs from the live epoch reads as zero.
module kdsc_count_table
	import kdsc_pkg::*;
(
	input  wire logic                clk,
	input  wire kdsc_cnt_req_t       req,
	input  wire logic [EPOCH_W-1:0]  epoch,
	output logic      [CNT_W-1:0]    rd_count
);

	logic [EPOCH_W+CNT_W-1:0] mem [VALUE_RANGE];
	logic [EPOCH_W+CNT_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.clr ? '0 : {epoch, req.wr_count};
		end
		rd_q <= mem[req.rd_addr];
	end

	assign rd_count = (rd_q[EPOCH_W+CNT_W-1:CNT_W] == epoch) ? rd_q[CNT_W-1:0] : '0;

endmodule
`default_nettype wire
